// ===== sv/fwto_pkg.sv =====
// Package for the FIFO with entry timeouts: widths, codes, record layout,
// controller/datapath command and status structs, and pointer arithmetic.
// No dependencies.
package fwto_pkg;

  localparam int Depth = 16;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = 5;
  localparam int IdW   = 16;
  localparam int TimeW = 32;
  localparam int WaitW = 16;
  localparam int RecW  = IdW + TimeW + WaitW;

  // Input command codes; the fourth code is a no-op
  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One stored customer record
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] arrival;
    logic [WaitW-1:0] wait_left;
  } rec_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;        // item accepted: clear pending result
    logic enq_write;    // append the input record
    logic set_full;     // flag enqueue on full
    logic set_empty;    // flag dequeue on empty
    logic deq_read;     // read oldest entry
    logic deq_capture;  // capture oldest entry and pop it
    logic tick_start;   // begin aging walk
    logic tick_step;    // process one entry of the walk
    logic load_out;     // move pending result to output register
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic tick_last;
    logic out_free;
  } sts_t;

  // Circular pointer add: a + b modulo Depth, with b at most Depth
  function automatic logic [AddrW-1:0] wrap_add(input logic [AddrW-1:0] a,
                                                input logic [CntW-1:0]  b);
    logic [CntW:0] s;
    s = (CntW+1)'(a) + (CntW+1)'(b);
    if (s >= (CntW+1)'(Depth)) begin
      s = s - (CntW+1)'(Depth);
    end
    return s[AddrW-1:0];
  endfunction

endpackage

// ===== sv/fifo_with_entry_timeouts_unit.sv =====
// Top level of the FIFO with entry timeouts.
// Depends on fwto_pkg, fwto_ctrl and fwto_dpath.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one command per transfer:
//   enqueue a record, dequeue the oldest record, or tick (age all entries
//   by one and drop those whose wait reaches zero). Each command returns
//   exactly one result transfer on the output channel (out_valid/out_stall)
//   with status, the dequeued record, the tick's removed count and the
//   queue length afterwards.
//   cfg_write_en/cfg_write_data set the capacity limit while idle.
// Command sequencing:
//   Enqueue and no-op do their work as the command is accepted; dequeue
//   adds one registered RAM read; tick walks the queue, reading one entry
//   per cycle from the single entry RAM read port and writing survivors
//   back packed toward the head. The result then waits for the output
//   register to be free, and only then is the next command taken.
// Reset:
//   Queue empty, capacity limit 16, no result pending. RAM is not cleared.
// Receiver stall:
//   One result waits in the output register; the next command is still
//   accepted and worked, and its result holds until the register frees.
module fifo_with_entry_timeouts_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [fwto_pkg::CntW-1:0]  cfg_write_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 cmd,
  input  logic [fwto_pkg::IdW-1:0]   customer_id,
  input  logic [fwto_pkg::TimeW-1:0] arrival_time,
  input  logic [fwto_pkg::WaitW-1:0] max_wait,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic [fwto_pkg::IdW-1:0]   out_customer_id,
  output logic [fwto_pkg::TimeW-1:0] out_arrival_time,
  output logic [fwto_pkg::WaitW-1:0] out_max_wait,
  output logic [fwto_pkg::CntW-1:0]  removed_count,
  output logic [fwto_pkg::CntW-1:0]  queue_length
);

  fwto_pkg::ctl_t ctl;
  fwto_pkg::sts_t sts;

  fwto_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  fwto_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .customer_id      (customer_id),
    .arrival_time     (arrival_time),
    .max_wait         (max_wait),
    .ctl              (ctl),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .out_customer_id  (out_customer_id),
    .out_arrival_time (out_arrival_time),
    .out_max_wait     (out_max_wait),
    .removed_count    (removed_count),
    .queue_length     (queue_length)
  );

endmodule

// ===== sv/fwto_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module fwto_ram #(
  parameter int Width    = 64,
  parameter int DepthRam = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DepthRam > 1) ? $clog2(DepthRam) : 1)-1:0] waddr,
  input  logic [Width-1:0]                              wdata,
  input  logic [((DepthRam > 1) ? $clog2(DepthRam) : 1)-1:0] raddr,
  output logic [Width-1:0]                              rdata
);

  logic [Width-1:0] mem [DepthRam];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/fwto_ctrl.sv =====
// Controller state machine for the FIFO with entry timeouts.
// Depends on fwto_pkg; drives fwto_dpath through ctl_t and reads sts_t.
module fwto_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       cmd,
  output logic             in_stall,
  input  fwto_pkg::sts_t   sts,
  output fwto_pkg::ctl_t   ctl
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEQ  = 4'b0010,
    S_TICK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.start  = 1'b1;
          state_next = S_DONE;
          case (fwto_pkg::cmd_t'(cmd))
            fwto_pkg::CMD_ENQ: begin
              if (sts.full) begin
                ctl.set_full = 1'b1;
              end else begin
                ctl.enq_write = 1'b1;
              end
            end
            fwto_pkg::CMD_DEQ: begin
              if (sts.empty) begin
                ctl.set_empty = 1'b1;
              end else begin
                ctl.deq_read = 1'b1;
                state_next   = S_DEQ;
              end
            end
            fwto_pkg::CMD_TICK: begin
              if (!sts.empty) begin
                ctl.tick_start = 1'b1;
                state_next     = S_TICK;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEQ: begin
        ctl.deq_capture = 1'b1;
        state_next      = S_DONE;
      end
      S_TICK: begin
        ctl.tick_step = 1'b1;
        if (sts.tick_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/fwto_dpath.sv =====
// Datapath for the FIFO with entry timeouts: circular entry RAM, head and
// count, aging walk counters, pending result and output register.
// Depends on fwto_pkg and fwto_ram.
module fwto_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [fwto_pkg::CntW-1:0]     cfg_write_data,
  input  logic [fwto_pkg::IdW-1:0]      customer_id,
  input  logic [fwto_pkg::TimeW-1:0]    arrival_time,
  input  logic [fwto_pkg::WaitW-1:0]    max_wait,
  input  fwto_pkg::ctl_t                ctl,
  output fwto_pkg::sts_t                sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [fwto_pkg::IdW-1:0]      out_customer_id,
  output logic [fwto_pkg::TimeW-1:0]    out_arrival_time,
  output logic [fwto_pkg::WaitW-1:0]    out_max_wait,
  output logic [fwto_pkg::CntW-1:0]     removed_count,
  output logic [fwto_pkg::CntW-1:0]     queue_length
);

  logic [fwto_pkg::CntW-1:0]  cap_limit;
  logic [fwto_pkg::CntW-1:0]  eff_limit;
  logic [fwto_pkg::AddrW-1:0] head;
  logic [fwto_pkg::CntW-1:0]  count;
  logic [fwto_pkg::AddrW-1:0] rd_idx;
  logic [fwto_pkg::CntW-1:0]  wr_cnt;
  logic [fwto_pkg::CntW-1:0]  wr_cnt_next;
  logic [fwto_pkg::CntW-1:0]  rd_pos_next;

  fwto_pkg::status_t pend_status;
  fwto_pkg::rec_t    pend_rec;
  logic [fwto_pkg::CntW-1:0] pend_removed;

  fwto_pkg::rec_t             rd_data;
  fwto_pkg::rec_t             wr_data;
  fwto_pkg::rec_t             aged_rec;
  logic                       we;
  logic [fwto_pkg::AddrW-1:0] waddr;
  logic [fwto_pkg::AddrW-1:0] raddr;
  logic                       survive;
  logic                       out_taken;

  // Limit saturated to the storage depth
  assign eff_limit = (cap_limit > fwto_pkg::CntW'(fwto_pkg::Depth)) ?
                     fwto_pkg::CntW'(fwto_pkg::Depth) : cap_limit;

  // Walk bookkeeping
  assign rd_pos_next = fwto_pkg::CntW'(rd_idx) + fwto_pkg::CntW'(1);
  assign survive     = (rd_data.wait_left != fwto_pkg::WaitW'(1));
  assign wr_cnt_next = survive ? (wr_cnt + fwto_pkg::CntW'(1)) : wr_cnt;

  // Aged record: zero wait holds at zero
  always_comb begin
    aged_rec = rd_data;
    if (rd_data.wait_left != '0) begin
      aged_rec.wait_left = rd_data.wait_left - fwto_pkg::WaitW'(1);
    end
  end

  // Status to controller
  assign out_taken     = out_valid && !out_stall;
  assign sts.full      = (count >= eff_limit);
  assign sts.empty     = (count == '0);
  assign sts.tick_last = (rd_pos_next == count);
  assign sts.out_free  = !out_valid || !out_stall;

  // RAM port muxing
  always_comb begin
    we      = 1'b0;
    waddr   = fwto_pkg::wrap_add(head, wr_cnt);
    wr_data = aged_rec;
    if (ctl.enq_write) begin
      we      = 1'b1;
      waddr   = fwto_pkg::wrap_add(head, count);
      wr_data = '{id: customer_id, arrival: arrival_time, wait_left: max_wait};
    end else if (ctl.tick_step && survive) begin
      we = 1'b1;
    end
    if (ctl.deq_read || ctl.tick_start) begin
      raddr = head;
    end else begin
      raddr = fwto_pkg::wrap_add(head, rd_pos_next);
    end
  end

  fwto_ram #(
    .Width    (fwto_pkg::RecW),
    .DepthRam (fwto_pkg::Depth)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_data),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Capacity register and queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= fwto_pkg::CntW'(fwto_pkg::Depth);
      head      <= '0;
      count     <= '0;
    end else begin
      if (cfg_write_en) begin
        cap_limit <= cfg_write_data;
      end
      if (ctl.enq_write) begin
        count <= count + fwto_pkg::CntW'(1);
      end else if (ctl.deq_capture) begin
        head  <= fwto_pkg::wrap_add(head, fwto_pkg::CntW'(1));
        count <= count - fwto_pkg::CntW'(1);
      end else if (ctl.tick_step && sts.tick_last) begin
        count <= wr_cnt_next;
      end
    end
  end

  // Walk counters and pending result
  always_ff @(posedge clk) begin
    if (ctl.set_full) begin
      pend_status <= fwto_pkg::ST_FULL;
    end else if (ctl.set_empty) begin
      pend_status <= fwto_pkg::ST_EMPTY;
    end else if (ctl.start) begin
      pend_status <= fwto_pkg::ST_OK;
    end
    if (ctl.deq_capture) begin
      pend_rec <= rd_data;
    end else if (ctl.start) begin
      pend_rec <= '0;
    end
    if (ctl.start) begin
      pend_removed <= '0;
    end else if (ctl.tick_step && !survive) begin
      pend_removed <= pend_removed + fwto_pkg::CntW'(1);
    end
    if (ctl.tick_start) begin
      rd_idx <= '0;
      wr_cnt <= '0;
    end else if (ctl.tick_step) begin
      rd_idx <= rd_idx + fwto_pkg::AddrW'(1);
      wr_cnt <= wr_cnt_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_taken) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      status           <= pend_status;
      out_customer_id  <= pend_rec.id;
      out_arrival_time <= pend_rec.arrival;
      out_max_wait     <= pend_rec.wait_left;
      removed_count    <= pend_removed;
      queue_length     <= count;
    end
  end

endmodule

// ===== tb/sv/fifo_with_entry_timeouts_unit_test.sv =====
// Testbench for fifo_with_entry_timeouts_unit: drives queue commands on a valid/stall
// channel, predicts every result with a shadow queue and checks each transfer field by field.
// Depends on fwto_pkg and the fifo_with_entry_timeouts_unit RTL.
module fifo_with_entry_timeouts_unit_test;

  localparam int QuietLimit = 4000;

  // Expected outcome of one command
  typedef struct packed {
    fwto_pkg::status_t                st;
    logic [fwto_pkg::IdW-1:0]         id;
    logic [fwto_pkg::TimeW-1:0]       arrival;
    logic [fwto_pkg::WaitW-1:0]       wait_left;
    logic [fwto_pkg::CntW-1:0]        removed;
    logic [fwto_pkg::CntW-1:0]        length;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write_en;
  logic [fwto_pkg::CntW-1:0] cfg_write_data;
  logic in_valid;
  logic in_stall;
  logic [1:0] cmd;
  logic [fwto_pkg::IdW-1:0] customer_id;
  logic [fwto_pkg::TimeW-1:0] arrival_time;
  logic [fwto_pkg::WaitW-1:0] max_wait;
  logic out_valid;
  logic out_stall;
  logic [1:0] status;
  logic [fwto_pkg::IdW-1:0] out_customer_id;
  logic [fwto_pkg::TimeW-1:0] out_arrival_time;
  logic [fwto_pkg::WaitW-1:0] out_max_wait;
  logic [fwto_pkg::CntW-1:0] removed_count;
  logic [fwto_pkg::CntW-1:0] queue_length;

  // Shadow copy of the queue and its limit
  fwto_pkg::rec_t shadow_entries[$];
  int unsigned shadow_limit;
  outcome_t due_results[$];
  outcome_t want;
  int error_count = 0;
  int quiet_cycles = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int stall_left = 0;

  fifo_with_entry_timeouts_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .customer_id(customer_id),
    .arrival_time(arrival_time),
    .max_wait(max_wait),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .out_customer_id(out_customer_id),
    .out_arrival_time(out_arrival_time),
    .out_max_wait(out_max_wait),
    .removed_count(removed_count),
    .queue_length(queue_length)
  );

  always #2 clk = ~clk;

  // Apply one command to the shadow queue and return its outcome
  function automatic outcome_t apply_queue_command(fwto_pkg::cmd_t c,
                                                   logic [fwto_pkg::IdW-1:0] id,
                                                   logic [fwto_pkg::TimeW-1:0] arr,
                                                   logic [fwto_pkg::WaitW-1:0] wt);
    outcome_t o;
    fwto_pkg::rec_t r;
    fwto_pkg::rec_t kept[$];
    int unsigned eff_limit;
    int unsigned gone;
    o = '0;
    o.st = fwto_pkg::ST_OK;
    gone = 0;
    eff_limit = (shadow_limit > fwto_pkg::Depth) ? fwto_pkg::Depth : shadow_limit;
    case (c)
      fwto_pkg::CMD_ENQ: begin
        if (shadow_entries.size() >= eff_limit) begin
          o.st = fwto_pkg::ST_FULL;
        end else begin
          r.id = id;
          r.arrival = arr;
          r.wait_left = wt;
          shadow_entries.push_back(r);
        end
      end
      fwto_pkg::CMD_DEQ: begin
        if (shadow_entries.size() == 0) begin
          o.st = fwto_pkg::ST_EMPTY;
        end else begin
          r = shadow_entries.pop_front();
          o.id = r.id;
          o.arrival = r.arrival;
          o.wait_left = r.wait_left;
        end
      end
      fwto_pkg::CMD_TICK: begin
        // a wait of one expires; a zero wait holds and never expires
        foreach (shadow_entries[i]) begin
          r = shadow_entries[i];
          if (r.wait_left == fwto_pkg::WaitW'(1)) begin
            gone++;
          end else begin
            if (r.wait_left != '0) r.wait_left = r.wait_left - fwto_pkg::WaitW'(1);
            kept.push_back(r);
          end
        end
        shadow_entries = kept;
      end
      default: ;
    endcase
    o.removed = gone[fwto_pkg::CntW-1:0];
    o.length = fwto_pkg::CntW'(shadow_entries.size());
    return o;
  endfunction

  task automatic report(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [fwto_pkg::TimeW-1:0] got,
                             logic [fwto_pkg::TimeW-1:0] exp_val);
    if (got !== exp_val) report($sformatf("%s got %0h want %0h", name, got, exp_val));
  endtask

  // Send one command; the expectation is recorded at the transfer edge
  task automatic send_item(fwto_pkg::cmd_t c, logic [fwto_pkg::IdW-1:0] id,
                           logic [fwto_pkg::TimeW-1:0] arr,
                           logic [fwto_pkg::WaitW-1:0] wt);
    in_valid <= 1'b1;
    cmd <= c;
    customer_id <= id;
    arrival_time <= arr;
    max_wait <= wt;
    do @(posedge clk); while (in_stall !== 1'b0);
    due_results.push_back(apply_queue_command(c, id, arr, wt));
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_random(fwto_pkg::cmd_t c);
    send_item(c, fwto_pkg::IdW'($urandom), $urandom, fwto_pkg::WaitW'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // Capacity limit is only written with the queue idle
  task automatic set_capacity(logic [fwto_pkg::CntW-1:0] v);
    wait_drained();
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    shadow_limit = 32'(v);
  endtask

  // Commands on an empty queue right after reset
  task automatic test_empty_queue();
    in_idle_pct = 20;
    out_idle_pct = 20;
    send_random(fwto_pkg::CMD_DEQ);
    send_random(fwto_pkg::CMD_TICK);
    send_random(fwto_pkg::CMD_NOP);
  endtask

  // Extreme field values, expiry at wait one, zero wait that never expires
  task automatic test_field_extremes();
    send_item(fwto_pkg::CMD_ENQ, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(fwto_pkg::CMD_ENQ, 16'h0000, 32'h0000_0000, 16'h0000);
    send_item(fwto_pkg::CMD_ENQ, 16'h1234, 32'h8000_0001, 16'h0001);
    send_item(fwto_pkg::CMD_ENQ, 16'h5A5A, 32'h0000_FFFF, 16'h0002);
    send_random(fwto_pkg::CMD_TICK);
    send_random(fwto_pkg::CMD_NOP);
    send_random(fwto_pkg::CMD_TICK);
    send_random(fwto_pkg::CMD_DEQ);
    send_random(fwto_pkg::CMD_DEQ);
    send_random(fwto_pkg::CMD_DEQ);
  endtask

  // Zero limit, limit lowered below the count, limit above the depth
  task automatic test_capacity_limits();
    set_capacity(5'd0);
    send_random(fwto_pkg::CMD_ENQ);
    set_capacity(5'd2);
    send_random(fwto_pkg::CMD_ENQ);
    send_random(fwto_pkg::CMD_ENQ);
    send_random(fwto_pkg::CMD_ENQ);
    set_capacity(5'd1);
    send_random(fwto_pkg::CMD_ENQ);
    send_random(fwto_pkg::CMD_DEQ);
    send_random(fwto_pkg::CMD_ENQ);
    send_random(fwto_pkg::CMD_DEQ);
    set_capacity(5'd31);
    send_random(fwto_pkg::CMD_ENQ);
    send_random(fwto_pkg::CMD_DEQ);
  endtask

  // One phase of random traffic under a given limit and command mix
  task automatic run_phase(int items, logic [fwto_pkg::CntW-1:0] lim, int enq_w,
                           int deq_w, int tick_w, int short_wait);
    int r;
    logic [fwto_pkg::WaitW-1:0] wt;
    set_capacity(lim);
    repeat (items) begin
      r = $urandom_range(0, 9);
      if (r < 6) wt = fwto_pkg::WaitW'($urandom_range(0, short_wait));
      else if (r < 8) wt = fwto_pkg::WaitW'($urandom_range(0, 1));
      else wt = fwto_pkg::WaitW'($urandom);
      r = $urandom_range(0, enq_w + deq_w + tick_w + 1);
      if (r < enq_w) send_item(fwto_pkg::CMD_ENQ, fwto_pkg::IdW'($urandom), $urandom, wt);
      else if (r < enq_w + deq_w) send_random(fwto_pkg::CMD_DEQ);
      else if (r < enq_w + deq_w + tick_w) send_random(fwto_pkg::CMD_TICK);
      else send_random(fwto_pkg::CMD_NOP);
    end
  endtask

  // Phases that fill, drain, age and mix, with idling on and off
  task automatic test_random_traffic();
    logic [fwto_pkg::CntW-1:0] lim;
    for (int p = 0; p < 14; p++) begin
      case (p)
        0: lim = 5'd16;
        1: lim = 5'd31;
        2: lim = 5'd0;
        3: lim = 5'd1;
        default: lim = fwto_pkg::CntW'($urandom_range(0, 31));
      endcase
      in_idle_pct = (p % 3 == 0) ? 0 : 20;
      out_idle_pct = (p % 3 == 1) ? 0 : 20;
      case (p % 4)
        0: run_phase(110, lim, 60, 15, 25, 8);
        1: run_phase(110, lim, 25, 50, 25, 8);
        2: run_phase(110, lim, 45, 10, 45, 3);
        default: run_phase(110, lim, 35, 30, 35, 20);
      endcase
    end
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_full_rate();
    in_idle_pct = 0;
    out_idle_pct = 0;
    run_phase(80, 5'd16, 50, 20, 30, 6);
    run_phase(80, 5'd31, 35, 30, 35, 12);
  endtask

  // Receiver stall in random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < out_idle_pct) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_results.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        want = due_results.pop_front();
        check_field("status", fwto_pkg::TimeW'(status), fwto_pkg::TimeW'(want.st));
        check_field("customer_id", fwto_pkg::TimeW'(out_customer_id),
                    fwto_pkg::TimeW'(want.id));
        check_field("arrival_time", out_arrival_time, want.arrival);
        check_field("max_wait", fwto_pkg::TimeW'(out_max_wait),
                    fwto_pkg::TimeW'(want.wait_left));
        check_field("removed_count", fwto_pkg::TimeW'(removed_count),
                    fwto_pkg::TimeW'(want.removed));
        check_field("queue_length", fwto_pkg::TimeW'(queue_length),
                    fwto_pkg::TimeW'(want.length));
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_write_en <= 1'b0;
    cfg_write_data <= '0;
    in_valid <= 1'b0;
    cmd <= fwto_pkg::CMD_NOP;
    customer_id <= '0;
    arrival_time <= '0;
    max_wait <= '0;
    shadow_limit = 16;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_queue();
    test_field_extremes();
    test_capacity_limits();
    test_random_traffic();
    test_full_rate();
    wait_drained();
    repeat (25) @(posedge clk);
    if (due_results.size() != 0) report("expected results left over at the end");
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/fwto_pkg.sv
sv/fwto_ram.sv
sv/fwto_ctrl.sv
sv/fwto_dpath.sv
sv/fifo_with_entry_timeouts_unit.sv
tb/sv/fifo_with_entry_timeouts_unit_test.sv
